// ===== design/urbc_pkg.sv =====
`default_nettype none

package urbc_pkg;

  localparam int unsigned RX_DEPTH_DEF = 64;
  localparam int unsigned TX_DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    OP_PUSH_TX = 2'd0,
    OP_POP_RX  = 2'd1,
    OP_LINE_RX = 2'd2,
    OP_TX_DONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] read_data;
    logic       send_valid;
    logic [7:0] send_byte;
    logic [6:0] rx_level;
    logic [6:0] tx_level;
  } out_item_t;

  typedef enum logic [1:0] {
    CS_IDLE   = 2'd0,
    CS_READ   = 2'd1,
    CS_UPDATE = 2'd2
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic read;
    logic update;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== design/urbc_ctrl.sv =====
`default_nettype none

module urbc_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  output urbc_pkg::ctrl_cmd_t    cmd
);

  urbc_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= urbc_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      urbc_pkg::CS_IDLE: begin
        if (start) state_next = urbc_pkg::CS_READ;
      end
      urbc_pkg::CS_READ:   state_next = urbc_pkg::CS_UPDATE;
      urbc_pkg::CS_UPDATE: state_next = urbc_pkg::CS_IDLE;
      default:             state_next = urbc_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    cmd.capture = 1'b0;
    cmd.read    = 1'b0;
    cmd.update  = 1'b0;
    case (state)
      urbc_pkg::CS_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      urbc_pkg::CS_READ:   cmd.read   = 1'b1;
      urbc_pkg::CS_UPDATE: cmd.update = 1'b1;
      default:             busy       = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/urbc_datapath.sv =====
`default_nettype none

module urbc_datapath #(
  parameter int unsigned RX_DEPTH = urbc_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = urbc_pkg::TX_DEPTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  urbc_pkg::ctrl_cmd_t   cmd,
  input  urbc_pkg::in_item_t    item,
  output logic                  strobe,
  output urbc_pkg::out_item_t   result
);

  localparam int unsigned RX_PTR_W  = $clog2(RX_DEPTH);
  localparam int unsigned TX_PTR_W  = $clog2(TX_DEPTH);
  localparam int unsigned RX_FILL_W = $clog2(RX_DEPTH + 1);
  localparam int unsigned TX_FILL_W = $clog2(TX_DEPTH + 1);

  logic [7:0] rx_store [RX_DEPTH];
  logic [7:0] tx_store [TX_DEPTH];

  urbc_pkg::op_t        op;
  logic [7:0]           data_byte;
  logic [7:0]           rx_rd_data;
  logic [7:0]           tx_rd_data;

  logic [RX_PTR_W-1:0]  rx_write_slot, rx_write_slot_next;
  logic [RX_PTR_W-1:0]  rx_read_slot, rx_read_slot_next;
  logic [RX_FILL_W-1:0] rx_fill, rx_fill_next;
  logic [TX_PTR_W-1:0]  tx_write_slot, tx_write_slot_next;
  logic [TX_PTR_W-1:0]  tx_read_slot, tx_read_slot_next;
  logic [TX_FILL_W-1:0] tx_fill, tx_fill_next;
  logic                 tx_busy, tx_busy_next;
  logic                 rx_we, tx_we;
  urbc_pkg::out_item_t  result_next;

  function automatic logic [RX_PTR_W-1:0] rx_wrap(input logic [RX_PTR_W-1:0] p);
    rx_wrap = (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : RX_PTR_W'(p + RX_PTR_W'(1));
  endfunction

  function automatic logic [TX_PTR_W-1:0] tx_wrap(input logic [TX_PTR_W-1:0] p);
    tx_wrap = (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : TX_PTR_W'(p + TX_PTR_W'(1));
  endfunction

  // captured command beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op        <= item.op;
      data_byte <= item.data_byte;
    end
  end

  // registered reads at the oldest slots
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rx_rd_data <= rx_store[rx_read_slot];
      tx_rd_data <= tx_store[tx_read_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && rx_we) rx_store[rx_write_slot] <= data_byte;
    if (cmd.update && tx_we) tx_store[tx_write_slot] <= data_byte;
  end

  always_comb begin
    rx_write_slot_next     = rx_write_slot;
    rx_read_slot_next      = rx_read_slot;
    rx_fill_next           = rx_fill;
    tx_write_slot_next     = tx_write_slot;
    tx_read_slot_next      = tx_read_slot;
    tx_fill_next           = tx_fill;
    tx_busy_next           = tx_busy;
    rx_we                  = 1'b0;
    tx_we                  = 1'b0;
    result_next.status     = urbc_pkg::ST_OK;
    result_next.read_data  = '0;
    result_next.send_valid = 1'b0;
    result_next.send_byte  = '0;
    case (op)
      urbc_pkg::OP_PUSH_TX: begin
        if (tx_fill == TX_FILL_W'(TX_DEPTH)) begin
          result_next.status = urbc_pkg::ST_FULL;
        end else begin
          tx_we              = 1'b1;
          tx_write_slot_next = tx_wrap(tx_write_slot);
          if (!tx_busy) begin
            // idle shifter means an empty queue: the new byte goes straight out
            tx_read_slot_next      = tx_wrap(tx_read_slot);
            tx_busy_next           = 1'b1;
            result_next.send_valid = 1'b1;
            result_next.send_byte  = data_byte;
          end else begin
            tx_fill_next = TX_FILL_W'(tx_fill + TX_FILL_W'(1));
          end
        end
      end
      urbc_pkg::OP_POP_RX: begin
        if (rx_fill == '0) begin
          result_next.status = urbc_pkg::ST_EMPTY;
        end else begin
          result_next.read_data = rx_rd_data;
          rx_read_slot_next     = rx_wrap(rx_read_slot);
          rx_fill_next          = RX_FILL_W'(rx_fill - RX_FILL_W'(1));
        end
      end
      urbc_pkg::OP_LINE_RX: begin
        if (rx_fill == RX_FILL_W'(RX_DEPTH)) begin
          result_next.status = urbc_pkg::ST_FULL;
        end else begin
          rx_we              = 1'b1;
          rx_write_slot_next = rx_wrap(rx_write_slot);
          rx_fill_next       = RX_FILL_W'(rx_fill + RX_FILL_W'(1));
        end
      end
      urbc_pkg::OP_TX_DONE: begin
        if (tx_fill != '0) begin
          result_next.send_valid = 1'b1;
          result_next.send_byte  = tx_rd_data;
          tx_read_slot_next      = tx_wrap(tx_read_slot);
          tx_fill_next           = TX_FILL_W'(tx_fill - TX_FILL_W'(1));
          tx_busy_next           = 1'b1;
        end else begin
          tx_busy_next = 1'b0;
        end
      end
      default: begin
        result_next.status = urbc_pkg::ST_OK;
      end
    endcase
    result_next.rx_level = 7'(rx_fill_next);
    result_next.tx_level = 7'(tx_fill_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_write_slot <= '0;
      rx_read_slot  <= '0;
      rx_fill       <= '0;
      tx_write_slot <= '0;
      tx_read_slot  <= '0;
      tx_fill       <= '0;
      tx_busy       <= 1'b0;
      strobe        <= 1'b0;
    end else begin
      strobe <= cmd.update;
      if (cmd.update) begin
        rx_write_slot <= rx_write_slot_next;
        rx_read_slot  <= rx_read_slot_next;
        rx_fill       <= rx_fill_next;
        tx_write_slot <= tx_write_slot_next;
        tx_read_slot  <= tx_read_slot_next;
        tx_fill       <= tx_fill_next;
        tx_busy       <= tx_busy_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) result <= result_next;
  end

endmodule

`default_nettype wire

// ===== design/uart_ring_buffer_controller_unit.sv =====
// Each accepted command beat passes through capture, registered queue read and update;
//   its result then shows on the ports, with strobe high for one cycle.
// A new beat is not taken while one is in progress (busy is high);
//   busy drops in the cycle the result is shown, so the next beat can be taken then.
// Results never stall: the receiver cannot hold a result beat off.
// Reset (rst, synchronous): both queues empty, transmitter idle, no strobe; storage kept.
`default_nettype none

module uart_ring_buffer_controller_unit #(
  parameter int unsigned RX_DEPTH = urbc_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = urbc_pkg::TX_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  urbc_pkg::in_item_t   item,
  output logic                 strobe,
  output urbc_pkg::out_item_t  result
);

  // Sequencer: IDLE takes the beat, READ fetches the oldest byte of each queue
  // from its memory (registered read), UPDATE commits pointers, fills, the
  // transmit busy mark and any memory write, and loads the result register.
  // Queue storage is not cleared; only bytes from written slots reach the result.
  urbc_pkg::ctrl_cmd_t cmd;

  urbc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath: two ring buffers with slot pointers and fill counts. A push with
  // the shifter idle forwards the pushed byte straight to send_byte, since the
  // transmit queue is always empty when the shifter is idle.
  urbc_datapath #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

endmodule

`default_nettype wire

// ===== design/urbc_checker.sv =====
`default_nettype none

module urbc_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  start,
  input wire                  busy,
  input wire                  strobe,
  input urbc_pkg::out_item_t  result
);

  wire accept = start && !busy;

  // the result strobe must follow each taken beat
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 strobe)
    else $error("result strobe missing three cycles after accept");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after accept");

  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("strobe held longer than one cycle");

  a_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("busy while result shown");

  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status == urbc_pkg::ST_FULL) |->
      (!result.send_valid && result.read_data == 8'd0))
    else $error("refused beat produced data");

endmodule

bind uart_ring_buffer_controller_unit urbc_checker u_urbc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

`default_nettype wire
